@@ rtl/core/cdds_pkg.sv @@
// Shared types, codes and constant tables for the charlieplexed digit display scanner.
package cdds_pkg;

    // Operation codes carried in the op field of an input item.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Display geometry.
    localparam int NUM_DIGITS   = 3;
    localparam int NUM_SEGMENTS = 8;

    // Decimal point lives in bit 7 of a frame byte; point code 3 means none.
    localparam logic [7:0] POINT_BIT = 8'b10000000;
    localparam logic [1:0] NO_POINT  = 2'd3;

    // Pin table entries: high nibble is the cathode pin, low nibble the anode pin.
    localparam logic [3:0] PIN_NIBBLE_MASK = 4'h0f;

    // Input item and result item as they cross the ports.
    typedef struct packed {
        logic        op;
        logic [15:0] number;
        logic [1:0]  point;
    } item_t;

    typedef struct packed {
        logic [7:0] pin_dir;
        logic [7:0] pin_out;
    } result_t;

    // Three display bytes, digit 0 in the low byte.
    typedef logic [NUM_DIGITS-1:0][7:0] frame_t;

    // Pin assignment for each digit and segment.
    localparam logic [7:0] PIN_MAP [NUM_DIGITS][NUM_SEGMENTS] = '{
        '{8'h05, 8'h03, 8'h01, 8'h20, 8'h02, 8'h10, 8'h15, 8'h00},
        '{8'h21, 8'h13, 8'h12, 8'h23, 8'h30, 8'h32, 8'h31, 8'h54},
        '{8'h34, 8'h24, 8'h41, 8'h04, 8'h14, 8'h43, 8'h42, 8'h53}
    };

    // Seven-segment font for decimal digits; codes above nine show blank.
    function automatic logic [7:0] font_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/core/charlieplexed_digit_display_scanner.sv @@
// Top level of the charlieplexed three-digit display scanner.
//
// The scanner takes one item per clock cycle on the item channel while item_stall
// is low. A write item loads the three-digit frame store and produces no result;
// a tick item lights at most one segment and produces one result carrying the pin
// enables and levels. A write is split into digits and converted to segment bytes
// on its way into the input register, and every item is then resolved against the
// frame store and the scan counters from the input register; a tick's result is
// registered in the result register, and items stream at one per cycle as long as
// result_stall stays low. The rate is set by the single input register and result
// register pair; a stalled result holds a tick in the input register, which then
// stalls the channel, while a write still leaves it.
// The frame store, counters and held output level are cleared by reset.
module charlieplexed_digit_display_scanner (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cdds_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output cdds_pkg::result_t result
);
    import cdds_pkg::*;

    // Input register stage.
    logic   s1_valid_reg;
    logic   s1_valid_next;
    logic   s1_op_reg;
    frame_t s1_frame_reg;
    frame_t split_frame;

    // Display state.
    frame_t     frame_reg;
    logic [1:0] digit_cnt_reg;
    logic [1:0] digit_cnt_next;
    logic [2:0] seg_cnt_reg;
    logic [2:0] seg_cnt_next;
    logic [7:0] level_reg;
    logic [7:0] level_next;

    // Result register.
    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;
    result_t res_next;

    logic       accept;
    logic       advance;
    logic       tick_advance;
    logic       write_advance;
    logic [1:0] digit_eff;
    logic       seg_lit;
    logic [7:0] pin_entry;
    logic [2:0] anode;
    logic [2:0] cathode;

    cdds_split u_split (
        .number (item.number),
        .point  (item.point),
        .frame  (split_frame)
    );

    // Handshake: a write always leaves the input stage, a tick needs room in
    // the result register.
    always_comb
    begin
        advance       = s1_valid_reg && (s1_op_reg == OP_WRITE || !res_valid_reg
                                         || !result_stall);
        tick_advance  = advance && s1_op_reg == OP_TICK;
        write_advance = advance && s1_op_reg == OP_WRITE;
        item_stall    = s1_valid_reg && !advance;
        accept        = item_valid && !item_stall;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Segment lookup for the current scan position.
    always_comb
    begin
        digit_eff = (digit_cnt_reg == 2'(NUM_DIGITS)) ? 2'd0 : digit_cnt_reg;
        seg_lit   = frame_reg[digit_eff][seg_cnt_reg];
        pin_entry = PIN_MAP[digit_eff][seg_cnt_reg];
        anode     = pin_entry[2:0] & PIN_NIBBLE_MASK[2:0];
        cathode   = pin_entry[6:4] & PIN_NIBBLE_MASK[2:0];
        if (seg_lit)
        begin
            level_next       = 8'b1 << anode;
            res_next.pin_dir = (8'b1 << anode) | (8'b1 << cathode);
        end
        else
        begin
            level_next       = level_reg;
            res_next.pin_dir = 8'h00;
        end
        res_next.pin_out = level_next;
    end

    // Scan counters: segment first, digit on segment wrap.
    always_comb
    begin
        seg_cnt_next   = seg_cnt_reg + 3'd1;
        digit_cnt_next = digit_eff;
        if (seg_cnt_reg == 3'(NUM_SEGMENTS - 1))
        begin
            digit_cnt_next = (digit_eff == 2'(NUM_DIGITS - 1)) ? 2'd0 : digit_eff + 2'd1;
        end
    end

    // Result register valid.
    always_comb
    begin
        if (tick_advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            frame_reg     <= '0;
            digit_cnt_reg <= 2'd0;
            seg_cnt_reg   <= 3'd0;
            level_reg     <= 8'h00;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (write_advance)
            begin
                frame_reg <= s1_frame_reg;
            end
            if (tick_advance)
            begin
                digit_cnt_reg <= digit_cnt_next;
                seg_cnt_reg   <= seg_cnt_next;
                level_reg     <= level_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= item.op;
            s1_frame_reg <= split_frame;
        end
        if (tick_advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // The held level is never more than one anode.
    a_level_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(level_reg))
        else $error("output level has more than one pin high");

    // A lit result drives its own anode, which must be enabled.
    a_lit_anode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pin_dir != 8'h00 |->
            result.pin_out != 8'h00 && (result.pin_dir & result.pin_out) == result.pin_out)
        else $error("lit segment without an enabled anode");

    // At most an anode and a cathode are enabled.
    a_two_pins: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $countones(result.pin_dir) <= 2)
        else $error("more than two pins enabled");

    // The digit counter stays within the display.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_cnt_reg != 2'(NUM_DIGITS))
        else $error("digit counter out of range");

    // A write leaves the scan position and level untouched.
    a_write_keeps_scan: assert property (@(posedge clk) disable iff (!rst_n)
        write_advance |=> seg_cnt_reg == $past(seg_cnt_reg)
            && level_reg == $past(level_reg))
        else $error("write transfer changed scan state");

endmodule

@@ rtl/core/cdds_split.sv @@
// Decimal digit split, font lookup and decimal point insertion for a write item.
module cdds_split (
    input  logic [15:0]     number,
    input  logic [1:0]      point,
    output cdds_pkg::frame_t frame
);
    import cdds_pkg::*;

    // Reciprocal constants, each exact over the full 16-bit input range.
    localparam logic [15:0] RECIP_10   = 16'd52429;   // 2^19 / 10, rounded up
    localparam logic [17:0] RECIP_100  = 18'd167773;  // 2^24 / 100, rounded up
    localparam logic [16:0] RECIP_1000 = 17'd67109;   // 2^26 / 1000, rounded up

    logic [31:0] prod_10;
    logic [33:0] prod_100;
    logic [32:0] prod_1000;
    logic [12:0] quot_10;
    logic [9:0]  quot_100;
    logic [6:0]  quot_1000;
    logic [15:0] rem_0;
    logic [12:0] rem_1;
    logic [9:0]  rem_2;
    logic [NUM_DIGITS-1:0][3:0] digits;

    // Three independent constant divisions by reciprocal multiplication.
    always_comb
    begin
        prod_10   = 32'(number) * 32'(RECIP_10);
        prod_100  = 34'(number) * 34'(RECIP_100);
        prod_1000 = 33'(number) * 33'(RECIP_1000);
        quot_10   = prod_10[31:19];
        quot_100  = prod_100[33:24];
        quot_1000 = prod_1000[32:26];
    end

    // Each digit is a quotient minus ten times the next quotient.
    always_comb
    begin
        rem_0 = number - (16'({quot_10, 3'b000}) + 16'({quot_10, 1'b0}));
        rem_1 = quot_10 - (13'({quot_100, 3'b000}) + 13'({quot_100, 1'b0}));
        rem_2 = quot_100 - (10'({quot_1000, 3'b000}) + 10'({quot_1000, 1'b0}));
        digits[0] = rem_0[3:0];
        digits[1] = rem_1[3:0];
        digits[2] = rem_2[3:0];
    end

    // Font lookup, then the decimal point on the chosen digit.
    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            frame[k] = font_of(digits[k]);
            if (point != NO_POINT && point == 2'(k))
            begin
                frame[k] = frame[k] | POINT_BIT;
            end
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the charlieplexed digit display scanner.
`timescale 1ns / 1ps

module testbench;
    import cdds_pkg::*;

    localparam int IDLE_PERCENT   = 23;
    localparam int RANDOM_ITEMS   = 700;
    localparam int CALM_FIRST     = 300;
    localparam int CALM_LAST      = 420;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PLAN_ROWS      = 20;

    // Segment patterns for the decimal digits zero to nine.
    localparam logic [7:0] SEG_FONT [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    // One directed row: the item, and a typed-in result where one is given.
    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } plan_row_t;

    typedef struct {
        bit      typed;
        result_t want;
    } typed_pins_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item_bus     = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_bus;

    // Scanner state as the predictor sees it.
    logic [7:0] frame_copy [NUM_DIGITS];
    logic [1:0] digit_pos;
    logic [2:0] segment_pos;
    logic [7:0] level_held;

    result_t     pins_due [$];
    typed_pins_t typed_due [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;

    // Directed rows: blank display after reset, all segments and the shared pin
    // on digit 0, the largest number with no point, zero, and ignored tick fields.
    plan_row_t plan [PLAN_ROWS] = '{
        '{'{OP_TICK,  16'd0,     2'd0},     1'b1, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b1, '{8'h00, 8'h00}},
        '{'{OP_WRITE, 16'd888,   2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b1, '{8'h01, 8'h01}},
        '{'{OP_WRITE, 16'hffff,  NO_POINT}, 1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_WRITE, 16'd0,     2'd2},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'd0,     2'd0},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_WRITE, 16'd999,   2'd1},     1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'hffff,  NO_POINT}, 1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'hffff,  NO_POINT}, 1'b0, '{8'h00, 8'h00}},
        '{'{OP_TICK,  16'hffff,  NO_POINT}, 1'b0, '{8'h00, 8'h00}}
    };

    charlieplexed_digit_display_scanner u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Load a frame or scan one segment; returns the pins for a tick.
    task automatic predict_pins(input item_t it, output bit lit_result, output result_t pins);
        int         value;
        int         d;
        int         s;
        logic [7:0] entry;
        pins       = '0;
        lit_result = 1'b0;
        if (it.op == OP_WRITE)
        begin
            value = int'(it.number);
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                frame_copy[k] = SEG_FONT[value % 10];
                value = value / 10;
            end
            if (it.point != NO_POINT)
                frame_copy[it.point] = frame_copy[it.point] | POINT_BIT;
        end
        else
        begin
            d = (int'(digit_pos) >= NUM_DIGITS) ? 0 : int'(digit_pos);
            s = int'(segment_pos);
            if (frame_copy[d][s])
            begin
                entry      = PIN_MAP[d][s];
                level_held = 8'b1 << entry[2:0];
                pins.pin_dir = (8'b1 << entry[2:0]) | (8'b1 << entry[6:4]);
            end
            pins.pin_out = level_held;
            lit_result   = 1'b1;
            // Advance the scan; the digit moves on when the segment wraps.
            s = s + 1;
            if (s >= NUM_SEGMENTS)
            begin
                s = 0;
                d = d + 1;
                if (d >= NUM_DIGITS)
                    d = 0;
            end
            segment_pos = 3'(s);
            digit_pos   = 2'(d);
        end
    endtask

    // Offer one item, idling at random first, and hold it until its transfer.
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        typed_due.push_back('{typed, want});
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item_bus   <= it;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // Receiver stalls at random except during the calm stretch.
    always @(negedge clk)
        result_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PERCENT);

    // Check result transfers, then predict accepted items.
    always @(posedge clk)
    begin
        bit          lit_result;
        result_t     pins;
        result_t     exp_pins;
        typed_pins_t typed_entry;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pins_due.size() == 0)
                begin
                    $error("result transfer with no expected result: pin_dir %h pin_out %h",
                           result_bus.pin_dir, result_bus.pin_out);
                    error_count++;
                end
                else
                begin
                    exp_pins = pins_due.pop_front();
                    if (result_bus.pin_dir !== exp_pins.pin_dir)
                    begin
                        $error("pin_dir expected %h actual %h",
                               exp_pins.pin_dir, result_bus.pin_dir);
                        error_count++;
                    end
                    if (result_bus.pin_out !== exp_pins.pin_out)
                    begin
                        $error("pin_out expected %h actual %h",
                               exp_pins.pin_out, result_bus.pin_out);
                        error_count++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                typed_entry = typed_due.pop_front();
                predict_pins(item_bus, lit_result, pins);
                if (lit_result)
                    pins_due.push_back(typed_entry.typed ? typed_entry.want : pins);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n && ((item_valid && !item_stall) || (result_valid && !result_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        item_t it;
        for (int k = 0; k < NUM_DIGITS; k++)
            frame_copy[k] = 8'h00;
        digit_pos   = '0;
        segment_pos = '0;
        level_held  = '0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows.
        for (int r = 0; r < PLAN_ROWS; r++)
            send_item(plan[r].it, plan[r].typed, plan[r].want);

        // Random items: mostly ticks, with writes of small and full-range numbers.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm      = (n >= CALM_FIRST) && (n < CALM_LAST);
            it.op     = ($urandom_range(99) < 20) ? OP_WRITE : OP_TICK;
            it.number = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                 : 16'($urandom_range(999));
            it.point  = 2'($urandom_range(3));
            send_item(it, 1'b0, '0);
        end
        calm = 1'b0;

        @(negedge clk);
        item_valid <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle.
        while (pins_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && pins_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
